@@ rtl/core/volume_breakout_detector_macros.svh @@
// assertion macros for the volume breakout detector
// expects clk and rst_n in the scope where a macro is used
`ifndef VOLUME_BREAKOUT_DETECTOR_MACROS_SVH
`define VOLUME_BREAKOUT_DETECTOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define VBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vbd_pkg.sv @@
// widths, constants, control word types and the microcode table of the
// volume breakout detector; no dependencies
package vbd_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int RING_DEPTH   = MAX_WINDOW + 1;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int WIN_W        = 7;
  localparam int PRICE_W      = 32;
  localparam int VOL_W        = 24;
  localparam int SUM_W        = VOL_W + $clog2(MAX_WINDOW);
  localparam int SQ_W         = 2 * VOL_W + $clog2(MAX_WINDOW);
  localparam int D_W          = SUM_W + 1;
  localparam int DD_W         = 2 * D_W;
  localparam int SP_W         = SQ_W + $clog2(MAX_WINDOW);
  localparam int ACC_W        = DD_W + WIN_W + 1;
  localparam int MUL_W        = 32;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int X_W          = PRICE_W + 11;
  localparam int WINDOW_RESET = 20;
  // price test: close * PRICE_NUM >= old_close * PRICE_DEN
  localparam int PRICE_NUM    = 1000;
  localparam int PRICE_DEN    = 1005;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LEAVE = STEP_W'(11);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(13);

  typedef enum logic [3:0] {
    A_PRICE, A_OLD, A_VOL, A_SUM, A_D, A_QLO, A_QHI,
    A_DDLO, A_DDHI, A_SPLO, A_SPHI, A_LEAVE
  } a_sel_t;

  typedef enum logic [2:0] {
    B_KNUM, B_KDEN, B_N, B_M, B_SUM, B_D, B_VOL, B_LEAVE
  } b_sel_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_X_LD, OP_POK, OP_D_LD, OP_ACC_NEG, OP_DD_LD, OP_ACC_ADD,
    OP_ACC_ADD_HI, OP_ACC_LD_SAVE, OP_ACC_SUB, OP_ACC_SUB_HI, OP_SQ_LEAVE,
    OP_FINISH
  } alu_op_t;

  typedef struct packed {
    a_sel_t              a_sel;
    b_sel_t              b_sel;
    alu_op_t             op;
    logic                jmp_nogo;
    logic [STEP_W-1:0]   target;
    logic                last;
  } ctrl_word_t;

  function automatic ctrl_word_t cw(input a_sel_t a, input b_sel_t b,
                                    input alu_op_t op, input logic jmp,
                                    input logic [STEP_W-1:0] tgt,
                                    input logic last);
    ctrl_word_t w;
    w.a_sel    = a;
    w.b_sel    = b;
    w.op       = op;
    w.jmp_nogo = jmp;
    w.target   = tgt;
    w.last     = last;
    return w;
  endfunction

  // each step issues one product and consumes the one issued a step before
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      STEP_W'(0):  w = cw(A_PRICE, B_KNUM,  OP_NOP,         1'b0, '0, 1'b0);
      STEP_W'(1):  w = cw(A_OLD,   B_KDEN,  OP_X_LD,        1'b0, '0, 1'b0);
      STEP_W'(2):  w = cw(A_VOL,   B_N,     OP_POK,         1'b0, '0, 1'b0);
      STEP_W'(3):  w = cw(A_SUM,   B_SUM,   OP_D_LD,        1'b0, '0, 1'b0);
      // no breakout possible: skip the spread arithmetic
      STEP_W'(4):  w = cw(A_D,     B_D,     OP_ACC_NEG,     1'b1, STEP_LEAVE, 1'b0);
      STEP_W'(5):  w = cw(A_QLO,   B_N,     OP_DD_LD,       1'b0, '0, 1'b0);
      STEP_W'(6):  w = cw(A_QHI,   B_N,     OP_ACC_ADD,     1'b0, '0, 1'b0);
      STEP_W'(7):  w = cw(A_DDLO,  B_M,     OP_ACC_ADD_HI,  1'b0, '0, 1'b0);
      STEP_W'(8):  w = cw(A_DDHI,  B_M,     OP_ACC_LD_SAVE, 1'b0, '0, 1'b0);
      STEP_W'(9):  w = cw(A_SPLO,  B_N,     OP_ACC_ADD_HI,  1'b0, '0, 1'b0);
      STEP_W'(10): w = cw(A_SPHI,  B_N,     OP_ACC_SUB,     1'b0, '0, 1'b0);
      STEP_W'(11): w = cw(A_LEAVE, B_LEAVE, OP_ACC_SUB_HI,  1'b0, '0, 1'b0);
      STEP_W'(12): w = cw(A_VOL,   B_VOL,   OP_SQ_LEAVE,    1'b0, '0, 1'b0);
      STEP_W'(13): w = cw(A_VOL,   B_VOL,   OP_FINISH,      1'b0, '0, 1'b1);
      default:     w = cw(A_VOL,   B_VOL,   OP_NOP,         1'b0, '0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/vbd_channels.sv @@
// valid/ready channel interfaces for bars in and signals out
// depends on vbd_pkg for the field widths
interface vbd_in_if;
  import vbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;
  logic [VOL_W-1:0]   bar_volume;
  modport source (output valid, close_price, bar_volume, input ready);
  modport sink   (input valid, close_price, bar_volume, output ready);
endinterface

interface vbd_out_if;
  logic valid;
  logic ready;
  logic buy_signal;
  logic history_full;
  modport source (output valid, buy_signal, history_full, input ready);
  modport sink   (input valid, buy_signal, history_full, output ready);
endinterface

@@ rtl/core/volume_breakout_detector.sv @@
// volume breakout detector: microcoded datapath around one shared multiplier
// depends on vbd_pkg, vbd_channels and volume_breakout_detector_macros.svh
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      close_price[31:0], bar_volume[23:0]
//   out_ch    out  valid/ready      buy_signal, history_full
//   cfg       in   cfg_we           cfg_wdata[6:0] = window_count
//
// an item skips the spread arithmetic when the history is short, the window is
// one bar, or a price or volume test fails; one 32x32 product per step
// the next item is taken as soon as the result register loads
// reset clears control and statistics only, the two rings start unwritten
// the final step holds while an earlier result still waits in out_ch
`include "volume_breakout_detector_macros.svh"

module volume_breakout_detector (
  input  logic                      clk,
  input  logic                      rst_n,
  vbd_in_if.sink                    in_ch,
  vbd_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [vbd_pkg::WIN_W-1:0] cfg_wdata
);
  import vbd_pkg::*;

  // control
  logic              busy_r;
  logic [STEP_W-1:0] pc_r;
  ctrl_word_t        word;
  logic              step_en;
  logic              in_acc;
  logic              go;
  logic              diff_pos;

  // history state
  logic [WIN_W-1:0]  window_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [WIN_W-1:0]  bars_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [PRICE_W-1:0] close_ring_r [RING_DEPTH];
  logic [VOL_W-1:0]   vol_ring_r   [RING_DEPTH];

  // per item datapath
  logic [WIN_W-1:0]   n_eff;
  logic [PTR_W:0]     back_sum;
  logic [PTR_W-1:0]   rd_addr;
  logic [WIN_W-1:0]   n_r;
  logic               full_r;
  logic [PRICE_W-1:0] p_r;
  logic [VOL_W-1:0]   v_r;
  logic [PRICE_W-1:0] old_r;
  logic [VOL_W-1:0]   leave_r;
  logic [X_W-1:0]     x_r;
  logic               pok_r;
  logic               dpos_r;
  logic [D_W-1:0]     d_r;
  logic [DD_W-1:0]    dd_r;
  logic [SP_W-1:0]    sp_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   p_lo;
  logic [ACC_W-1:0]   p_hi;
  logic [D_W-1:0]     nv;

  // result register
  logic out_valid_r;
  logic out_buy_r;
  logic out_full_r;

  assign word    = ucode_rom(pc_r);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign step_en = !(word.last && out_valid_r && !out_ch.ready);

  assign in_ch.ready         = rst_n && !busy_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.buy_signal   = out_buy_r;
  assign out_ch.history_full = out_full_r;

  // clamp the window to 1..MAX_WINDOW
  always_comb begin
    n_eff = window_r;
    if (window_r == '0) begin
      n_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(MAX_WINDOW)) begin
      n_eff = WIN_W'(MAX_WINDOW);
    end
  end

  // slot written n bars ago
  always_comb begin
    back_sum = {1'b0, ptr_r} + (PTR_W+1)'(RING_DEPTH) - (PTR_W+1)'(n_eff);
    if (back_sum >= (PTR_W+1)'(RING_DEPTH)) begin
      back_sum = back_sum - (PTR_W+1)'(RING_DEPTH);
    end
    rd_addr = back_sum[PTR_W-1:0];
  end

  always_comb begin
    case (word.a_sel)
      A_PRICE: mul_a = p_r;
      A_OLD:   mul_a = old_r;
      A_VOL:   mul_a = MUL_W'(v_r);
      A_SUM:   mul_a = MUL_W'(sum_r);
      A_D:     mul_a = MUL_W'(d_r);
      A_QLO:   mul_a = sq_r[MUL_W-1:0];
      A_QHI:   mul_a = MUL_W'(sq_r[SQ_W-1:MUL_W]);
      A_DDLO:  mul_a = dd_r[MUL_W-1:0];
      A_DDHI:  mul_a = MUL_W'(dd_r[DD_W-1:MUL_W]);
      A_SPLO:  mul_a = sp_r[MUL_W-1:0];
      A_SPHI:  mul_a = MUL_W'(sp_r[SP_W-1:MUL_W]);
      A_LEAVE: mul_a = MUL_W'(leave_r);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (word.b_sel)
      B_KNUM:  mul_b = MUL_W'(PRICE_NUM);
      B_KDEN:  mul_b = MUL_W'(PRICE_DEN);
      B_N:     mul_b = MUL_W'(n_r);
      B_M:     mul_b = MUL_W'(n_r - WIN_W'(1));
      B_SUM:   mul_b = MUL_W'(sum_r);
      B_D:     mul_b = MUL_W'(d_r);
      B_VOL:   mul_b = MUL_W'(v_r);
      B_LEAVE: mul_b = MUL_W'(leave_r);
      default: mul_b = '0;
    endcase
  end

  assign p_lo = ACC_W'(prod_r);
  assign p_hi = {prod_r[ACC_W-MUL_W-1:0], MUL_W'(0)};
  assign nv   = prod_r[D_W-1:0];

  // accumulator builds the spread, then d^2*(n-1) - n*spread
  always_comb begin
    case (word.op)
      OP_ACC_NEG:     acc_nxt = '0 - p_lo;
      OP_ACC_ADD:     acc_nxt = acc_r + p_lo;
      OP_ACC_ADD_HI:  acc_nxt = acc_r + p_hi;
      OP_ACC_LD_SAVE: acc_nxt = p_lo;
      OP_ACC_SUB:     acc_nxt = acc_r - p_lo;
      OP_ACC_SUB_HI:  acc_nxt = acc_r - p_hi;
      default:        acc_nxt = acc_r;
    endcase
  end

  assign go       = full_r && (n_r != WIN_W'(1)) && pok_r && dpos_r;
  assign diff_pos = !acc_r[ACC_W-1] && (acc_r != '0);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      pc_r   <= '0;
    end else if (busy_r && step_en) begin
      if (word.last) begin
        busy_r <= 1'b0;
      end else if (word.jmp_nogo && !go) begin
        pc_r <= word.target;
      end else begin
        pc_r <= pc_r + STEP_W'(1);
      end
    end
  end

  // history state, cleared by reset and by any window write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_W'(WINDOW_RESET);
      ptr_r    <= '0;
      bars_r   <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
      ptr_r    <= '0;
      bars_r   <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
    end else if (busy_r && step_en) begin
      case (word.op)
        OP_SQ_LEAVE: begin
          if (full_r) begin
            sq_r <= sq_r - SQ_W'(prod_r);
          end
        end
        OP_FINISH: begin
          sq_r  <= sq_r + SQ_W'(prod_r);
          sum_r <= sum_r - (full_r ? SUM_W'(leave_r) : SUM_W'(0)) + SUM_W'(v_r);
          ptr_r <= (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
          if ({1'b0, bars_r} < ({1'b0, n_r} + (WIN_W+1)'(1))) begin
            bars_r <= bars_r + WIN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // rings: write the new bar and fetch the one leaving, both at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      close_ring_r[ptr_r] <= in_ch.close_price;
      vol_ring_r[ptr_r]   <= in_ch.bar_volume;
      old_r               <= close_ring_r[rd_addr];
      leave_r             <= vol_ring_r[rd_addr];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_r    <= in_ch.close_price;
      v_r    <= in_ch.bar_volume;
      n_r    <= n_eff;
      full_r <= (bars_r >= n_eff);
    end
    if (busy_r && step_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      acc_r  <= acc_nxt;
      case (word.op)
        OP_X_LD:        x_r   <= prod_r[X_W-1:0];
        OP_POK:         pok_r <= (x_r >= prod_r[X_W-1:0]);
        OP_D_LD: begin
          dpos_r <= (nv > D_W'(sum_r));
          d_r    <= nv - D_W'(sum_r);
        end
        OP_DD_LD:       dd_r  <= prod_r[DD_W-1:0];
        OP_ACC_LD_SAVE: sp_r  <= acc_r[SP_W-1:0];
        // both flags load together with the result valid
        OP_FINISH: begin
          out_buy_r  <= go && diff_pos;
          out_full_r <= full_r;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (busy_r && step_en && (word.op == OP_FINISH)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  `VBD_ASSERT_NEXT(a_item_starts, in_acc, busy_r && (pc_r == '0), "item not at step zero")
  `VBD_ASSERT_NEXT(a_last_holds, busy_r && !step_en, busy_r && $stable(pc_r), "final step ran on")
  `VBD_ASSERT_IMPL(a_buy_needs_full, out_valid_r && out_buy_r, out_full_r, "buy, history short")
  `VBD_ASSERT_IMPL(a_pc_in_program, busy_r, pc_r <= LAST_STEP, "step past program")

endmodule
